FILE: hw/rtl/sdh_pkg.sv
// Shared types, constants and helper functions for the scan datagram header parser.
// Used by sdh_ctrl, sdh_dp and scan_datagram_header_parser.
package sdh_pkg;

	localparam int HEADER_BYTES  = 40;
	localparam int CONTENT_TYPES = 16;
	localparam int DIV_STEPS     = 17;

	localparam logic [15:0] TYPE_MASK = 16'((32'd1 << CONTENT_TYPES) - 32'd1);

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_ENCODER = 2'd1;
	localparam logic [1:0] KIND_LAYOUT  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV1,
		ST_DIV2,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic take;
		logic div_step;
		logic div_last1;
		logic load_layout;
	} cmd_t;

	typedef struct packed {
		logic lay_byte;
		logic out_free;
	} sts_t;

	function automatic logic [4:0] popcount16(input logic [15:0] m);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 16; i++) begin
			n = n + 5'(m[i]);
		end
		return n;
	endfunction

	// lowest set bit of m at or above from, or 16 when none
	function automatic logic [4:0] next_type(input logic [15:0] m, input logic [4:0] from);
		logic [4:0] r;
		r = 5'd16;
		for (int i = 15; i >= 0; i--) begin
			if (m[i] && (5'(i) >= from)) begin
				r = 5'(i);
			end
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/sdh_ctrl.sv
// Controller state machine for the scan datagram header parser.
// Depends on sdh_pkg; drives the datapath sdh_dp by command struct.
module sdh_ctrl
	import sdh_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t     state_q, state_d;
	logic [4:0] cnt_q;
	logic       cnt_last;

	assign cnt_last = (cnt_q == 5'(DIV_STEPS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && in_ready && sts.lay_byte) state_d = ST_DIV1;
			ST_DIV1: if (cnt_last) state_d = ST_DIV2;
			ST_DIV2: if (cnt_last) state_d = ST_LOAD;
			ST_LOAD: if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd             = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = sts.out_free;
				cmd.take = in_valid && sts.out_free;
			end
			ST_DIV1: begin
				cmd.div_step  = 1'b1;
				cmd.div_last1 = cnt_last;
			end
			ST_DIV2: cmd.div_step = 1'b1;
			ST_LOAD: cmd.load_layout = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV1 || state_q == ST_DIV2) begin
				cnt_q <= cnt_last ? 5'd0 : cnt_q + 5'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

FILE: hw/rtl/sdh_dp.sv
// Datapath of the scan datagram header parser: header fields, step and encoder
// gathering, a shared restoring divider and the output record register. Uses sdh_pkg.
module sdh_dp
	import sdh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        cfg_valid,
	input  logic [63:0] cfg_data,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  record_kind,
	output logic [23:0] source_id,
	output logic [31:0] profile_seq,
	output logic [63:0] wide_value,
	output logic [31:0] part_number,
	output logic [31:0] part_count,
	output logic [3:0]  content_type_index,
	output logic [15:0] column_step,
	output logic [16:0] value_count,
	output logic [23:0] payload_offset,
	output logic [19:0] payload_bytes,
	output logic        final_record
);

	logic [63:0] size_table_q;
	logic [15:0] pos_q;
	logic [23:0] source_q;
	logic [63:0] stamp_q;
	logic [15:0] mask_q;
	logic [7:0]  enc_total_q;
	logic [31:0] pnum_q;
	logic [31:0] pcnt_q;
	logic [15:0] col_start_q;
	logic [15:0] col_end_q;
	logic [31:0] seq_q;
	logic [63:0] gather_q;
	logic [4:0]  cursor_q;
	logic [23:0] offset_q;
	logic [15:0] step_q;
	logic        bad_q;
	logic [16:0] dq_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic        out_valid_q;

	logic [4:0]  types;
	logic [15:0] enc_start;
	logic [15:0] enc_end;
	logic [15:0] rel;
	logic        in_hdr, in_steps, in_enc;
	logic        hdr_done, enc_done;
	logic        out_load;
	logic [15:0] mask_hdr;
	logic [4:0]  types_hdr;
	logic [15:0] step_new;
	logic [16:0] cols;
	logic [32:0] r2;
	logic        ge;
	logic [32:0] diff;
	logic [16:0] cnt;
	logic [3:0]  nib;
	logic [20:0] size_full;
	logic [19:0] size;
	logic [4:0]  cursor_next;

	assign types     = popcount16(mask_q);
	assign enc_start = 16'(HEADER_BYTES) + {10'd0, types, 1'b0};
	assign enc_end   = enc_start + {5'd0, enc_total_q, 3'd0};
	assign rel       = pos_q - enc_start;
	assign in_hdr    = pos_q < 16'(HEADER_BYTES);
	assign in_steps  = !in_hdr && (pos_q < enc_start);
	assign in_enc    = !in_hdr && !in_steps && (pos_q < enc_end);
	assign hdr_done  = pos_q == 16'(HEADER_BYTES - 1);
	assign enc_done  = in_enc && (rel[2:0] == 3'd7);
	assign mask_hdr  = mask_q & TYPE_MASK;
	assign types_hdr = popcount16(mask_hdr);
	assign step_new  = {gather_q[7:0], data_byte};
	assign cols      = {1'b0, col_end_q} - {1'b0, col_start_q} + 17'd1;

	// a new record enters the output register this cycle
	assign out_load  = (cmd.take && (hdr_done || enc_done)) || cmd.load_layout;

	assign sts.lay_byte = in_steps && pos_q[0];
	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

	// one restoring step of the shared divider
	assign r2   = {rem_q, dq_q[16]};
	assign ge   = r2 >= {1'b0, dvs_q};
	assign diff = r2 - {1'b0, dvs_q};

	assign cnt = (bad_q || pcnt_q == '0) ? 17'd0 : dq_q + 17'(rem_q > pnum_q);
	assign nib = size_table_q[{cursor_q[3:0], 2'b00} +: 4];
	assign size_full   = {17'd0, nib} * {4'd0, cnt};
	assign size        = size_full[19:0];
	assign cursor_next = next_type(mask_q, cursor_q + 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_table_q <= '0;
			pos_q        <= '0;
			source_q     <= '0;
			stamp_q      <= '0;
			mask_q       <= '0;
			enc_total_q  <= '0;
			pnum_q       <= '0;
			pcnt_q       <= '0;
			col_start_q  <= '0;
			col_end_q    <= '0;
			seq_q        <= '0;
			gather_q     <= '0;
			cursor_q     <= '0;
			offset_q     <= '0;
			step_q       <= '0;
			bad_q        <= 1'b0;
			dq_q         <= '0;
			rem_q        <= '0;
			dvs_q        <= '0;
			out_valid_q  <= 1'b0;
			record_kind        <= KIND_HEADER;
			source_id          <= '0;
			profile_seq        <= '0;
			wide_value         <= '0;
			part_number        <= '0;
			part_count         <= '0;
			content_type_index <= '0;
			column_step        <= '0;
			value_count        <= '0;
			payload_offset     <= '0;
			payload_bytes      <= '0;
			final_record       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_table_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.take) begin
				if (in_hdr) begin
					case (pos_q)
						16'd4:  source_q[23:16] <= data_byte;
						16'd5:  source_q[15:8]  <= data_byte;
						16'd6:  source_q[7:0]   <= data_byte;
						16'd18, 16'd19: mask_q  <= {mask_q[7:0], data_byte};
						16'd22: enc_total_q     <= data_byte;
						16'd32, 16'd33: col_start_q <= {col_start_q[7:0], data_byte};
						16'd34, 16'd35: col_end_q   <= {col_end_q[7:0], data_byte};
						default: begin
							if (pos_q >= 16'd8 && pos_q <= 16'd15)
								stamp_q <= {stamp_q[55:0], data_byte};
							if (pos_q >= 16'd24 && pos_q <= 16'd27)
								pnum_q <= {pnum_q[23:0], data_byte};
							if (pos_q >= 16'd28 && pos_q <= 16'd31)
								pcnt_q <= {pcnt_q[23:0], data_byte};
							if (pos_q >= 16'd36 && pos_q <= 16'd39)
								seq_q <= {seq_q[23:0], data_byte};
						end
					endcase
					if (hdr_done) begin
						mask_q   <= mask_hdr;
						offset_q <= 24'(HEADER_BYTES) + {18'd0, types_hdr, 1'b0}
							+ {13'd0, enc_total_q, 3'd0};
						cursor_q <= next_type(mask_hdr, 5'd0);
						record_kind     <= KIND_HEADER;
						source_id       <= source_q;
						profile_seq     <= {seq_q[23:0], data_byte};
						wide_value      <= stamp_q;
						part_number     <= pnum_q;
						part_count      <= pcnt_q;
						content_type_index <= '0;
						column_step     <= '0;
						value_count     <= '0;
						payload_offset  <= '0;
						payload_bytes   <= '0;
						final_record    <= (types_hdr == '0) && (enc_total_q == '0);
					end
				end else if (in_steps) begin
					if (!last_byte) begin
						gather_q <= {48'd0, pos_q[0] ? step_new : {8'd0, data_byte}};
					end
					if (pos_q[0]) begin
						// start the count division: columns over step
						step_q <= step_new;
						bad_q  <= (col_end_q < col_start_q) || (step_new == '0);
						dq_q   <= cols;
						rem_q  <= '0;
						dvs_q  <= {16'd0, step_new};
					end
				end else if (in_enc) begin
					if (!last_byte) begin
						gather_q <= {gather_q[55:0], data_byte};
					end
					if (enc_done) begin
						record_kind     <= KIND_ENCODER;
						source_id       <= '0;
						profile_seq     <= '0;
						wide_value      <= {gather_q[55:0], data_byte};
						part_number     <= pnum_q;
						part_count      <= pcnt_q;
						content_type_index <= '0;
						column_step     <= '0;
						value_count     <= '0;
						payload_offset  <= '0;
						payload_bytes   <= '0;
						final_record    <= (pos_q == enc_end - 16'd1);
					end
				end

				if (last_byte) begin
					pos_q    <= '0;
					gather_q <= '0;
				end else if (pos_q != 16'hFFFF) begin
					pos_q <= pos_q + 16'd1;
				end
			end

			if (cmd.div_step) begin
				dq_q <= {dq_q[15:0], ge};
				if (cmd.div_last1) begin
					// quotient stays in dq; divide it next by the part count
					rem_q <= '0;
					dvs_q <= pcnt_q;
				end else begin
					rem_q <= ge ? diff[31:0] : r2[31:0];
				end
			end

			if (cmd.load_layout) begin
				record_kind     <= KIND_LAYOUT;
				source_id       <= '0;
				profile_seq     <= '0;
				wide_value      <= '0;
				part_number     <= pnum_q;
				part_count      <= pcnt_q;
				content_type_index <= cursor_q[3:0];
				column_step     <= step_q;
				value_count     <= cnt;
				payload_offset  <= offset_q;
				payload_bytes   <= size;
				final_record    <= (cursor_next == 5'd16) && (enc_total_q == '0);
				offset_q        <= offset_q + {4'd0, size};
				cursor_q        <= cursor_next;
			end
		end
	end

endmodule

FILE: hw/rtl/scan_datagram_header_parser.sv
// Top level of the scan datagram header parser: joins controller and datapath.
// Depends on sdh_pkg, sdh_ctrl and sdh_dp.
//
// channel  | handshake              | payload
// in       | in_valid / in_ready    | data_byte, last_byte
// out      | out_valid / out_ready  | record_kind .. final_record
// cfg      | cfg_valid / cfg_ready  | cfg_data (element size nibbles)
//
// Header, encoder and skipped bytes are taken in the idle state without a divider pass.
// A column step byte that closes a layout starts two 17-step passes of the shared
// restoring divider in ST_DIV1 and ST_DIV2; ST_LOAD loads the record once the output is free.
// A byte is taken only while the output register is empty or being drained.
// Reset clears all header state; configuration is always accepted.
module scan_datagram_header_parser
	import sdh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  record_kind,
	output logic [23:0] source_id,
	output logic [31:0] profile_seq,
	output logic [63:0] wide_value,
	output logic [31:0] part_number,
	output logic [31:0] part_count,
	output logic [3:0]  content_type_index,
	output logic [15:0] column_step,
	output logic [16:0] value_count,
	output logic [23:0] payload_offset,
	output logic [19:0] payload_bytes,
	output logic        final_record
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	sdh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sdh_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_valid          (cfg_valid),
		.cfg_data           (cfg_data),
		.data_byte          (data_byte),
		.last_byte          (last_byte),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.record_kind        (record_kind),
		.source_id          (source_id),
		.profile_seq        (profile_seq),
		.wide_value         (wide_value),
		.part_number        (part_number),
		.part_count         (part_count),
		.content_type_index (content_type_index),
		.column_step        (column_step),
		.value_count        (value_count),
		.payload_offset     (payload_offset),
		.payload_bytes      (payload_bytes),
		.final_record       (final_record)
	);

endmodule

FILE: tb/scan_datagram_header_parser_tb.sv
// Self-checking testbench for scan_datagram_header_parser: byte stream in, records out.
// Depends on sdh_pkg (record kinds, header size) and the parser RTL.
module scan_datagram_header_parser_tb
	import sdh_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] src;
		logic [31:0] seq;
		logic [63:0] wide;
		logic [31:0] pnum;
		logic [31:0] pcnt;
		logic [3:0]  ctype;
		logic [15:0] step;
		logic [16:0] vcnt;
		logic [23:0] offs;
		logic [19:0] psize;
		logic        fin;
	} dg_record_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} dg_byte_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  record_kind;
	logic [23:0] source_id;
	logic [31:0] profile_seq;
	logic [63:0] wide_value;
	logic [31:0] part_number;
	logic [31:0] part_count;
	logic [3:0]  content_type_index;
	logic [15:0] column_step;
	logic [16:0] value_count;
	logic [23:0] payload_offset;
	logic [19:0] payload_bytes;
	logic        final_record;

	scan_datagram_header_parser i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.record_kind(record_kind), .source_id(source_id),
		.profile_seq(profile_seq), .wide_value(wide_value),
		.part_number(part_number), .part_count(part_count),
		.content_type_index(content_type_index), .column_step(column_step),
		.value_count(value_count), .payload_offset(payload_offset),
		.payload_bytes(payload_bytes), .final_record(final_record)
	);

	dg_byte_t   byte_queue[$];
	dg_record_t record_queue[$];
	int  failures;
	int  cycle_count;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_left;
	bit  in_took;

	// mirror of the parser state
	logic [63:0] elem_sizes;
	logic [15:0] pos;
	logic [23:0] src_r;
	logic [63:0] ts_r;
	logic [15:0] mask_r;
	logic [7:0]  enc_r;
	logic [31:0] pnum_r;
	logic [31:0] pcnt_r;
	logic [15:0] col_lo;
	logic [15:0] col_hi;
	logic [31:0] seq_r;
	logic [63:0] gather;
	logic [4:0]  cursor;
	logic [23:0] run_offs;

	function automatic logic [4:0] first_type_from(input logic [15:0] m, input int from);
		for (int i = from; i < CONTENT_TYPES; i++)
			if (m[i]) return 5'(i);
		return 5'(CONTENT_TYPES);
	endfunction

	task automatic parser_reset();
		pos = '0; src_r = '0; ts_r = '0; mask_r = '0; enc_r = '0;
		pnum_r = '0; pcnt_r = '0; col_lo = '0; col_hi = '0; seq_r = '0;
		gather = '0; cursor = '0; run_offs = '0; elem_sizes = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic lst);
		int p, types, enc_start, enc_end;
		longint unsigned cols, q, cnt, size;
		logic [3:0] t;
		dg_record_t r;
		bit have;
		p = pos;
		types = $countones(mask_r);
		enc_start = HEADER_BYTES + 2 * types;
		enc_end = enc_start + 8 * enc_r;
		have = 0;
		r = '0;
		r.pnum = pnum_r;
		r.pcnt = pcnt_r;
		if (p < HEADER_BYTES) begin
			case (p)
				4: src_r[23:16] = b;
				5: src_r[15:8] = b;
				6: src_r[7:0] = b;
				18, 19: mask_r = {mask_r[7:0], b};
				22: enc_r = b;
				32, 33: col_lo = {col_lo[7:0], b};
				34, 35: col_hi = {col_hi[7:0], b};
				default: begin
					if (p >= 8 && p <= 15) ts_r = {ts_r[55:0], b};
					else if (p >= 24 && p <= 27) pnum_r = {pnum_r[23:0], b};
					else if (p >= 28 && p <= 31) pcnt_r = {pcnt_r[23:0], b};
					else if (p >= 36) seq_r = {seq_r[23:0], b};
				end
			endcase
			if (p == HEADER_BYTES - 1) begin
				mask_r &= TYPE_MASK;
				types = $countones(mask_r);
				run_offs = 24'(HEADER_BYTES + 2 * types + 8 * enc_r);
				cursor = first_type_from(mask_r, 0);
				r.kind = KIND_HEADER;
				r.src = src_r;
				r.seq = seq_r;
				r.wide = ts_r;
				r.pnum = pnum_r;
				r.pcnt = pcnt_r;
				r.fin = (types == 0 && enc_r == 0);
				have = 1;
			end
		end else if (p < enc_start) begin
			if (((p - HEADER_BYTES) % 2) == 0) begin
				gather = {56'd0, b};
			end else begin
				t = cursor[3:0];
				gather = {48'd0, gather[7:0], b};
				cnt = 0;
				if (col_hi >= col_lo && gather != 0 && pcnt_r != 0) begin
					cols = longint'(col_hi) - longint'(col_lo) + 1;
					q = cols / gather;
					cnt = q / pcnt_r;
					if ((q % pcnt_r) > pnum_r) cnt++;
				end
				size = elem_sizes[4*t +: 4] * cnt;
				r.kind = KIND_LAYOUT;
				r.ctype = t;
				r.step = gather[15:0];
				r.vcnt = 17'(cnt);
				r.offs = run_offs;
				r.psize = 20'(size);
				run_offs = 24'(run_offs + size);
				cursor = first_type_from(mask_r, t + 1);
				r.fin = (cursor >= CONTENT_TYPES && enc_r == 0);
				have = 1;
			end
		end else if (p < enc_end) begin
			gather = {gather[55:0], b};
			if (((p - enc_start) % 8) == 7) begin
				r.kind = KIND_ENCODER;
				r.wide = gather;
				r.fin = (p == enc_end - 1);
				have = 1;
			end
		end
		if (lst) begin
			pos = '0;
			gather = '0;
		end else if (pos != 16'hFFFF) begin
			pos++;
		end
		if (have) record_queue.insert(record_queue.size(), r);
	endtask

	// step < 0 picks a random step per content type; 0 < cut < length truncates the datagram
	task automatic queue_datagram(input logic [15:0] mask, input logic [7:0] enc,
			input logic [31:0] pn, input logic [31:0] pc, input logic [15:0] cs,
			input logic [15:0] ce, input int step, input int tail, input int cut);
		logic [7:0] bytes[$];
		int sel, n;
		for (int i = 0; i < HEADER_BYTES; i++) bytes.insert(bytes.size(), 8'($urandom));
		{bytes[18], bytes[19]} = mask;
		bytes[22] = enc;
		{bytes[24], bytes[25], bytes[26], bytes[27]} = pn;
		{bytes[28], bytes[29], bytes[30], bytes[31]} = pc;
		{bytes[32], bytes[33]} = cs;
		{bytes[34], bytes[35]} = ce;
		for (int i = 0; i < $countones(mask); i++) begin
			sel = $urandom_range(9);
			if (step >= 0) n = step;
			else if (sel == 0) n = 0;
			else if (sel == 1) n = 16'hFFFF;
			else if (sel < 6) n = $urandom_range(1, 8);
			else n = $urandom_range(65535);
			bytes.insert(bytes.size(), 8'(n >> 8));
			bytes.insert(bytes.size(), 8'(n));
		end
		for (int i = 0; i < 8 * enc + tail; i++) bytes.insert(bytes.size(), 8'($urandom));
		if (cut > 0 && cut < bytes.size()) n = cut;
		else n = bytes.size();
		for (int i = 0; i < n; i++)
			byte_queue.insert(byte_queue.size(), dg_byte_t'{bytes[i], i == n - 1});
	endtask

	task automatic queue_random_datagram();
		logic [15:0] mask;
		logic [31:0] pc, pn;
		logic [15:0] cs, ce;
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) mask = '0;
		else if (sel == 1) mask = 16'hFFFF;
		else begin
			mask = '0;
			for (int i = 0; i < $urandom_range(1, 3); i++) mask[$urandom_range(15)] = 1'b1;
		end
		sel = $urandom_range(9);
		if (sel == 0) pc = '0;
		else if (sel == 1) pc = 32'hFFFFFFFF;
		else pc = $urandom_range(1, 6);
		pn = ($urandom_range(4) == 0) ? 32'($urandom) : 32'($urandom_range(0, 6));
		cs = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
		ce = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(cs + $urandom_range(0, 3000));
		queue_datagram(mask, 8'($urandom_range(0, 3)), pn, pc, cs, ce, -1,
			$urandom_range(0, 5), ($urandom_range(6) == 0) ? $urandom_range(1, 60) : 0);
	endtask

	task automatic queue_noise();
		int n;
		n = $urandom_range(1, 30);
		for (int i = 0; i < n; i++)
			byte_queue.insert(byte_queue.size(), dg_byte_t'{8'($urandom), i == n - 1});
	endtask

	task automatic write_sizes(input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		elem_sizes = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (byte_queue.size() != 0 || in_valid || record_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			failures++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// input side: accept, predict, and note the handshake for the driver
	always @(posedge clk) begin
		in_took = in_valid && in_ready;
		if (in_took) parse_byte(data_byte, last_byte);
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				{data_byte, last_byte} <= byte_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		dg_record_t want;
		if (out_valid && out_ready) begin
			if (record_queue.size() == 0) begin
				$display("%0t: unexpected record: expected none, actual kind %0d",
					$time, record_kind);
				failures++;
			end else begin
				want = record_queue.pop_front();
				check_field("record_kind", want.kind, record_kind);
				check_field("source_id", want.src, source_id);
				check_field("profile_seq", want.seq, profile_seq);
				check_field("wide_value", want.wide, wide_value);
				check_field("part_number", want.pnum, part_number);
				check_field("part_count", want.pcnt, part_count);
				check_field("content_type_index", want.ctype, content_type_index);
				check_field("column_step", want.step, column_step);
				check_field("value_count", want.vcnt, value_count);
				check_field("payload_offset", want.offs, payload_offset);
				check_field("payload_bytes", want.psize, payload_bytes);
				check_field("final_record", want.fin, final_record);
			end
		end
	end

	initial begin
		logic [63:0] sizes[4];
		int idle_tab[4];
		int stall_tab[4];
		int added;
		sizes = '{64'hFFFFFFFFFFFFFFFF, 64'h0123456789ABCDEF, {$urandom, $urandom}, 64'h0};
		idle_tab = '{0, 66, 0, 27};
		stall_tab = '{0, 0, 66, 27};
		failures = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		in_took = 0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		parser_reset();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes of the header and the special counts
		write_sizes(64'hFFFFFFFFFFFFFFFF);
		queue_datagram(16'h0000, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0, -1, 0, 0);
		queue_datagram(16'hFFFF, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd0, 16'hFFFF,
			1, 2, 80);
		queue_datagram(16'h8001, 8'd1, 32'd0, 32'd1, 16'd0, 16'hFFFF, 1, 0, 0);
		queue_datagram(16'h0003, 8'd0, 32'd1, 32'd0, 16'd10, 16'd20, 1, 0, 0);
		queue_datagram(16'h0005, 8'd0, 32'd0, 32'd3, 16'd20, 16'd10, 2, 0, 0);
		queue_datagram(16'h0011, 8'd2, 32'd2, 32'd3, 16'd0, 16'd9, 0, 3, 0);
		queue_datagram(16'h0110, 8'd2, 32'd0, 32'd3, 16'd0, 16'd10, 1, 0, 45);
		queue_datagram(16'h00F0, 8'd0, 32'd0, 32'd1, 16'd0, 16'd99, 3, 0, 20);
		byte_queue.insert(byte_queue.size(), dg_byte_t'{8'hFF, 1'b1});
		byte_queue.insert(byte_queue.size(), dg_byte_t'{8'h00, 1'b1});
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_sizes(sizes[ph]);
			send_idle_pct = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			// long receiver hold-off so the parser backs up into its input
			if (ph == 0) hold_left = 400;
			added = 0;
			while (added < 50) begin
				added -= byte_queue.size();
				if ($urandom_range(7) == 0) queue_noise();
				else queue_random_datagram();
				added += byte_queue.size();
			end
			drain();
		end

		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
